// File: design/crmp_pkg.sv
package crmp_pkg;

    // Width of the hex accumulator and the range stores.
    localparam int VALUE_BITS = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARROW1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ARROW2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT = 3'd6;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
    localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_ERR  = 2'd1,
        ST_END  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_AFTDELIM = 4'd1,
        PH_LO_BS    = 4'd2,
        PH_LO_X     = 4'd3,
        PH_LO_D     = 4'd4,
        PH_HI_BS    = 4'd5,
        PH_HI_X     = 4'd6,
        PH_HI_D     = 4'd7,
        PH_ARROW1   = 4'd8,
        PH_SG_X     = 4'd9,
        PH_SG_D     = 4'd10,
        PH_ARROW2   = 4'd11,
        PH_TG_BS    = 4'd12,
        PH_TG_X     = 4'd13,
        PH_TG_D     = 4'd14,
        PH_PEND_ERR = 4'd15
    } phase_t;

    typedef struct packed {
        logic [7:0] delim;
        logic [7:0] open;
        logic [7:0] dash;
        logic [7:0] close;
        logic [7:0] arrow1;
        logic [7:0] arrow2;
        logic [7:0] comment;
    } cfg_t;

    // One input byte after classification. All match flags are low at end of input.
    typedef struct packed {
        logic       eof;
        logic       nl;
        logic       cmt;
        logic       delim;
        logic       open;
        logic       dash;
        logic       close;
        logic       arrow1;
        logic       arrow2;
        logic       bs;
        logic       x;
        logic       hex;
        logic [3:0] hex_val;
    } cls_t;

endpackage

// File: design/code_range_mapping_parser_top.sv
// Parser for the records of a code-conversion table, fed one text byte per transaction.
// Input channel (s_*): tdata carries the byte, tlast marks end of input instead of a byte.
// Result channel (m_*): tdata carries source_low, source_high, target_low and target_high
// from the lowest bits up; tuser carries the status (record done, format error, or end of
// input at record start). Error and end results carry zero data.
// Configuration channel (cfg_*): writes one of the seven separator bytes by index; it is
// always ready, and the user must ensure it is written only while the parser is idle; the
// block does not enforce this. Throughput is one byte per cycle while the result channel
// is not back-pressured, set by the parser step in the back end (one state transition and
// one 4-bit shift-add of the accumulator per byte). A result is presented on m_tvalid once
// its completing byte passes the input register, classified-byte queue and result register.
// A four-entry queue between the classifier and the parser lets input keep flowing
// while the receiver stalls; once the queue and the input register fill, s_tready drops.
// Reset clears all control state, empties the queue and restores the separator defaults.
module code_range_mapping_parser_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] char_code
    input  logic                           s_tlast,   // end_of_input
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [127:0]                   m_tdata,   // source_low, source_high,
                                                      // target_low, target_high
    output logic [1:0]                     m_tuser,   // status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [crmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    crmp_pkg::cfg_t cfg_reg, cfg_next;
    logic           q_full;
    logic           q_push;
    crmp_pkg::cls_t q_in;
    logic           q_valid;
    logic           q_pop;
    crmp_pkg::cls_t q_head;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                crmp_pkg::CFG_DELIM:   cfg_next.delim   = cfg_data;
                crmp_pkg::CFG_OPEN:    cfg_next.open    = cfg_data;
                crmp_pkg::CFG_DASH:    cfg_next.dash    = cfg_data;
                crmp_pkg::CFG_CLOSE:   cfg_next.close   = cfg_data;
                crmp_pkg::CFG_ARROW1:  cfg_next.arrow1  = cfg_data;
                crmp_pkg::CFG_ARROW2:  cfg_next.arrow2  = cfg_data;
                crmp_pkg::CFG_COMMENT: cfg_next.comment = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delim   <= 8'd44;
            cfg_reg.open    <= 8'd91;
            cfg_reg.dash    <= 8'd45;
            cfg_reg.close   <= 8'd93;
            cfg_reg.arrow1  <= 8'd45;
            cfg_reg.arrow2  <= 8'd62;
            cfg_reg.comment <= 8'd35;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    crmp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    crmp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    crmp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // Error and end-of-input results never carry range data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != crmp_pkg::ST_DONE) |-> (m_tdata == '0))
        else $error("non-record result carries data");

    // Reset leaves no result pending and an empty queue.
    assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !q_valid))
        else $error("state survived reset");

    // The queue is never pushed while full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("queue overflow");

    // Input stalls only while the queue is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_full)
        else $error("input stalled with room in the queue");
`endif

endmodule

// File: design/crmp_front.sv
module crmp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  crmp_pkg::cfg_t    cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] char_code
    input  logic              s_tlast,   // end_of_input
    input  logic              q_full,
    output logic              q_push,
    output crmp_pkg::cls_t    q_item
);

    logic           fr_valid_reg, fr_valid_next;
    crmp_pkg::cls_t fr_item_reg;
    crmp_pkg::cls_t cls_c;
    logic           take;

    always_comb begin
        logic [7:0] c;
        logic       b;
        c = s_tdata;
        b = !s_tlast;
        cls_c.eof    = s_tlast;
        cls_c.nl     = b && (c == crmp_pkg::CHAR_NEWLINE);
        cls_c.cmt    = b && (c == cfg.comment);
        cls_c.delim  = b && (c == cfg.delim);
        cls_c.open   = b && (c == cfg.open);
        cls_c.dash   = b && (c == cfg.dash);
        cls_c.close  = b && (c == cfg.close);
        cls_c.arrow1 = b && (c == cfg.arrow1);
        cls_c.arrow2 = b && (c == cfg.arrow2);
        cls_c.bs     = b && (c == crmp_pkg::CHAR_BACKSLASH);
        cls_c.x      = b && (c == crmp_pkg::CHAR_LOWER_X || c == crmp_pkg::CHAR_UPPER_X);
        cls_c.hex    = 1'b0;
        cls_c.hex_val = 4'd0;
        if (b && c >= 8'h30 && c <= 8'h39) begin
            cls_c.hex     = 1'b1;
            cls_c.hex_val = c[3:0];
        end else if (b && ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))) begin
            cls_c.hex     = 1'b1;
            cls_c.hex_val = c[3:0] + 4'd9;
        end
    end

    assign q_push   = fr_valid_reg && !q_full;
    assign s_tready = !fr_valid_reg || !q_full;
    assign take     = s_tvalid && s_tready;
    assign q_item   = fr_item_reg;

    always_comb begin
        fr_valid_next = fr_valid_reg;
        if (take) begin
            fr_valid_next = 1'b1;
        end else if (q_push) begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            fr_item_reg <= cls_c;
        end
    end

endmodule

// File: design/crmp_fifo.sv
module crmp_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  crmp_pkg::cls_t    push_item,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output crmp_pkg::cls_t    head
);

    crmp_pkg::cls_t                 mem_reg [crmp_pkg::QUEUE_DEPTH];
    logic [crmp_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [crmp_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [crmp_pkg::QUEUE_AW:0]    count_reg, count_next;
    logic                           do_pop;

    assign full   = (count_reg == (crmp_pkg::QUEUE_AW+1)'(crmp_pkg::QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == crmp_pkg::QUEUE_AW'(crmp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == crmp_pkg::QUEUE_AW'(crmp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/crmp_back.sv
module crmp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  crmp_pkg::cls_t    q_item,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [127:0]      m_tdata,   // source_low, source_high, target_low, target_high
    output logic [1:0]        m_tuser    // status
);

    localparam int VB = crmp_pkg::VALUE_BITS;

    crmp_pkg::phase_t phase_reg, phase_next;
    logic [VB-1:0]    acc_reg, acc_next;
    logic             digit_reg, digit_next;
    logic [VB-1:0]    lo_reg, lo_next;
    logic [VB-1:0]    hi_reg, hi_next;
    logic             raw_reg, raw_next;
    logic             cmt_reg, cmt_next;
    logic             drain_reg, drain_next;

    logic             go;
    logic             emit_c;
    crmp_pkg::status_t st_c;
    logic [127:0]     data_c;

    logic             out_valid_reg, out_valid_next;
    logic [127:0]     out_data_reg;
    logic [1:0]       out_user_reg;

    function automatic logic [31:0] out_word(input logic [VB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    // Byte filtering ahead of the grammar: newline escape, comments, error drain.
    always_comb begin
        go = 1'b0;
        if (phase_reg == crmp_pkg::PH_PEND_ERR || drain_reg) begin
            go = 1'b0;
        end else if (cmt_reg) begin
            go = q_item.eof;
        end else if (raw_reg) begin
            go = !q_item.cmt;
        end else if (q_item.eof) begin
            go = 1'b1;
        end else begin
            go = !q_item.nl && !q_item.cmt;
        end
    end

    always_comb begin
        logic fail;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        digit_next = digit_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        raw_next   = raw_reg;
        cmt_next   = cmt_reg;
        drain_next = drain_reg;
        emit_c     = 1'b0;
        st_c       = crmp_pkg::ST_DONE;
        fail       = 1'b0;

        if (phase_reg == crmp_pkg::PH_PEND_ERR) begin
            phase_next = crmp_pkg::PH_START;
            drain_next = !q_item.eof;
            emit_c     = 1'b1;
            st_c       = crmp_pkg::ST_ERR;
        end else if (drain_reg) begin
            if (q_item.eof) begin
                drain_next = 1'b0;
                raw_next   = 1'b0;
                cmt_next   = 1'b0;
                phase_next = crmp_pkg::PH_START;
            end
        end else if (cmt_reg) begin
            if (q_item.eof) begin
                cmt_next = 1'b0;
            end else if (q_item.nl) begin
                cmt_next = 1'b0;
                raw_next = 1'b1;
            end
        end else if (raw_reg) begin
            raw_next = 1'b0;
            if (q_item.cmt) begin
                cmt_next = 1'b1;
            end
        end else if (!q_item.eof) begin
            if (q_item.nl) begin
                raw_next = 1'b1;
            end else if (q_item.cmt) begin
                cmt_next = 1'b1;
            end
        end

        if (go) begin
            case (phase_reg)
                crmp_pkg::PH_START: begin
                    if (q_item.eof) begin
                        emit_c = 1'b1;
                        st_c   = crmp_pkg::ST_END;
                    end else if (q_item.delim) begin
                        phase_next = crmp_pkg::PH_AFTDELIM;
                    end else if (q_item.open) begin
                        phase_next = crmp_pkg::PH_LO_BS;
                    end else if (q_item.bs) begin
                        phase_next = crmp_pkg::PH_SG_X;
                    end else begin
                        fail = 1'b1;
                    end
                end
                crmp_pkg::PH_AFTDELIM: begin
                    if (q_item.open) begin
                        phase_next = crmp_pkg::PH_LO_BS;
                    end else if (q_item.bs) begin
                        phase_next = crmp_pkg::PH_SG_X;
                    end else begin
                        fail = 1'b1;
                    end
                end
                crmp_pkg::PH_LO_BS: begin
                    if (q_item.bs) phase_next = crmp_pkg::PH_LO_X;
                    else fail = 1'b1;
                end
                crmp_pkg::PH_HI_BS: begin
                    if (q_item.bs) phase_next = crmp_pkg::PH_HI_X;
                    else fail = 1'b1;
                end
                crmp_pkg::PH_TG_BS: begin
                    if (q_item.bs) phase_next = crmp_pkg::PH_TG_X;
                    else fail = 1'b1;
                end
                crmp_pkg::PH_LO_X, crmp_pkg::PH_HI_X, crmp_pkg::PH_SG_X,
                crmp_pkg::PH_TG_X: begin
                    if (q_item.x) begin
                        acc_next   = '0;
                        digit_next = 1'b0;
                        case (phase_reg)
                            crmp_pkg::PH_LO_X: phase_next = crmp_pkg::PH_LO_D;
                            crmp_pkg::PH_HI_X: phase_next = crmp_pkg::PH_HI_D;
                            crmp_pkg::PH_SG_X: phase_next = crmp_pkg::PH_SG_D;
                            default:           phase_next = crmp_pkg::PH_TG_D;
                        endcase
                    end else begin
                        fail = 1'b1;
                    end
                end
                crmp_pkg::PH_LO_D, crmp_pkg::PH_HI_D, crmp_pkg::PH_SG_D,
                crmp_pkg::PH_TG_D: begin
                    if (q_item.hex) begin
                        acc_next   = {acc_reg[VB-5:0], 4'b0000} + VB'(q_item.hex_val);
                        digit_next = 1'b1;
                    end else if (!digit_reg) begin
                        fail = 1'b1;
                    end else begin
                        case (phase_reg)
                            crmp_pkg::PH_LO_D: begin
                                lo_next = acc_reg;
                                if (q_item.dash) phase_next = crmp_pkg::PH_HI_BS;
                                else fail = 1'b1;
                            end
                            crmp_pkg::PH_HI_D: begin
                                hi_next = acc_reg;
                                if (q_item.close) phase_next = crmp_pkg::PH_ARROW1;
                                else fail = 1'b1;
                            end
                            crmp_pkg::PH_SG_D: begin
                                lo_next = acc_reg;
                                hi_next = acc_reg;
                                if (q_item.arrow1) phase_next = crmp_pkg::PH_ARROW2;
                                else fail = 1'b1;
                            end
                            default: begin
                                // Target complete; the closing byte starts the next record.
                                emit_c = 1'b1;
                                st_c   = crmp_pkg::ST_DONE;
                                if (q_item.eof) phase_next = crmp_pkg::PH_START;
                                else if (q_item.delim) phase_next = crmp_pkg::PH_AFTDELIM;
                                else if (q_item.open) phase_next = crmp_pkg::PH_LO_BS;
                                else if (q_item.bs) phase_next = crmp_pkg::PH_SG_X;
                                else phase_next = crmp_pkg::PH_PEND_ERR;
                            end
                        endcase
                    end
                end
                crmp_pkg::PH_ARROW1: begin
                    if (q_item.arrow1) phase_next = crmp_pkg::PH_ARROW2;
                    else fail = 1'b1;
                end
                crmp_pkg::PH_ARROW2: begin
                    if (q_item.arrow2) phase_next = crmp_pkg::PH_TG_BS;
                    else fail = 1'b1;
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
        end

        if (fail) begin
            phase_next = crmp_pkg::PH_START;
            drain_next = !q_item.eof;
            emit_c     = 1'b1;
            st_c       = crmp_pkg::ST_ERR;
        end
    end

    always_comb begin
        logic [VB-1:0] span_end;
        span_end = acc_reg + hi_reg - lo_reg;
        data_c   = '0;
        if (st_c == crmp_pkg::ST_DONE) begin
            data_c = {out_word(span_end), out_word(acc_reg), out_word(hi_reg), out_word(lo_reg)};
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = emit_c;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= crmp_pkg::PH_START;
            digit_reg     <= 1'b0;
            raw_reg       <= 1'b0;
            cmt_reg       <= 1'b0;
            drain_reg     <= 1'b0;
            acc_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                phase_reg <= phase_next;
                digit_reg <= digit_next;
                raw_reg   <= raw_next;
                cmt_reg   <= cmt_next;
                drain_reg <= drain_next;
                acc_reg   <= acc_next;
                lo_reg    <= lo_next;
                hi_reg    <= hi_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emit_c) begin
            out_data_reg <= data_c;
            out_user_reg <= st_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: tb/sv/tb_code_range_mapping_parser_top.sv
module tb_code_range_mapping_parser_top;
    import crmp_pkg::*;

    typedef struct packed {
        logic [31:0] source_low;
        logic [31:0] source_high;
        logic [31:0] target_low;
        logic [31:0] target_high;
        status_t     status;
    } mapping_t;

    typedef struct packed {
        logic       eof;
        logic [7:0] ch;
    } text_byte_t;

    // Separator bytes after reset: , [ - ] - > #
    localparam cfg_t DEFAULT_SEPARATORS = '{delim: 8'h2C, open: 8'h5B, dash: 8'h2D,
                                            close: 8'h5D, arrow1: 8'h2D, arrow2: 8'h3E,
                                            comment: 8'h23};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [127:0]         m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    text_byte_t  text_queue[$];
    logic [7:0]  record_text[$];
    mapping_t    expected_maps[$];
    int unsigned bytes_queued = 0;
    int unsigned mismatches   = 0;

    logic        in_fire         = 1'b0;
    bit          no_send_gaps    = 1'b0;
    bit          no_recv_stalls  = 1'b0;
    bit          long_hold_req   = 1'b0;
    bit          long_hold_taken = 1'b0;
    int unsigned send_gap  = 0;
    int unsigned recv_gap  = 0;
    int unsigned hold_left = 0;

    // Parser state as the table text is consumed.
    cfg_t                  sep = DEFAULT_SEPARATORS;
    phase_t                phase = PH_START;
    logic [VALUE_BITS-1:0] acc, lo_store, hi_store;
    bit                    digit_seen, raw_next, in_cmt, draining;

    code_range_mapping_parser_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic mapping_t blank_result(status_t st);
        mapping_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic bit reject_byte(bit eof, output mapping_t r);
        phase = PH_START;
        if (!eof) draining = 1'b1;
        r = blank_result(ST_ERR);
        return 1'b1;
    endfunction

    // The byte after the optional delimiter must open a range or start a number.
    function automatic bit begin_body(bit eof, logic [7:0] c, output mapping_t r);
        if (!eof && c == sep.open) begin
            phase = PH_LO_BS;
            return 1'b0;
        end
        if (!eof && c == CHAR_BACKSLASH) begin
            phase = PH_SG_X;
            return 1'b0;
        end
        return reject_byte(eof, r);
    endfunction

    function automatic bit parse_record_byte(bit eof, logic [7:0] c, output mapping_t r);
        int d;
        d = eof ? -1 : hex_digit(c);
        case (phase)
            PH_START: begin
                if (eof) begin
                    r = blank_result(ST_END);
                    return 1'b1;
                end
                if (c == sep.delim) begin
                    phase = PH_AFTDELIM;
                    return 1'b0;
                end
                return begin_body(eof, c, r);
            end
            PH_AFTDELIM: return begin_body(eof, c, r);
            PH_LO_BS, PH_HI_BS, PH_TG_BS: begin
                if (eof || c != CHAR_BACKSLASH) return reject_byte(eof, r);
                phase = phase_t'(phase + 4'd1);
                return 1'b0;
            end
            PH_LO_X, PH_HI_X, PH_SG_X, PH_TG_X: begin
                if (eof || (c != CHAR_LOWER_X && c != CHAR_UPPER_X)) return reject_byte(eof, r);
                acc = '0;
                digit_seen = 1'b0;
                phase = phase_t'(phase + 4'd1);
                return 1'b0;
            end
            PH_LO_D, PH_HI_D, PH_SG_D, PH_TG_D: begin
                if (d >= 0) begin
                    acc = (acc << 4) + VALUE_BITS'(d);
                    digit_seen = 1'b1;
                    return 1'b0;
                end
                if (!digit_seen) return reject_byte(eof, r);
                if (phase == PH_LO_D) begin
                    lo_store = acc;
                    if (eof || c != sep.dash) return reject_byte(eof, r);
                    phase = PH_HI_BS;
                    return 1'b0;
                end
                if (phase == PH_HI_D) begin
                    hi_store = acc;
                    if (eof || c != sep.close) return reject_byte(eof, r);
                    phase = PH_ARROW1;
                    return 1'b0;
                end
                if (phase == PH_SG_D) begin
                    lo_store = acc;
                    hi_store = acc;
                    if (eof || c != sep.arrow1) return reject_byte(eof, r);
                    phase = PH_ARROW2;
                    return 1'b0;
                end
                // The target is complete; the byte that ended it starts the next record.
                r.source_low  = 32'(lo_store);
                r.source_high = 32'(hi_store);
                r.target_low  = 32'(acc);
                r.target_high = 32'(acc + hi_store - lo_store);
                r.status      = ST_DONE;
                phase = PH_START;
                if (eof) return 1'b1;
                if (c == sep.delim) phase = PH_AFTDELIM;
                else if (c == sep.open) phase = PH_LO_BS;
                else if (c == CHAR_BACKSLASH) phase = PH_SG_X;
                else phase = PH_PEND_ERR;
                return 1'b1;
            end
            PH_ARROW1: begin
                if (eof || c != sep.arrow1) return reject_byte(eof, r);
                phase = PH_ARROW2;
                return 1'b0;
            end
            PH_ARROW2: begin
                if (eof || c != sep.arrow2) return reject_byte(eof, r);
                phase = PH_TG_BS;
                return 1'b0;
            end
            default: return reject_byte(eof, r);
        endcase
    endfunction

    // Handles draining, comments and the raw byte after a newline around the parser.
    function automatic bit map_record_step(bit eof, logic [7:0] c, output mapping_t r);
        if (phase == PH_PEND_ERR) begin
            phase = PH_START;
            draining = !eof;
            r = blank_result(ST_ERR);
            return 1'b1;
        end
        if (draining) begin
            if (eof) begin
                draining = 1'b0;
                raw_next = 1'b0;
                in_cmt   = 1'b0;
                phase    = PH_START;
            end
            return 1'b0;
        end
        if (in_cmt) begin
            if (eof) begin
                in_cmt = 1'b0;
                return parse_record_byte(1'b1, c, r);
            end
            if (c == CHAR_NEWLINE) begin
                in_cmt   = 1'b0;
                raw_next = 1'b1;
            end
            return 1'b0;
        end
        if (raw_next) begin
            raw_next = 1'b0;
            if (!eof && c == sep.comment) begin
                in_cmt = 1'b1;
                return 1'b0;
            end
            return parse_record_byte(eof, c, r);
        end
        if (eof) return parse_record_byte(1'b1, c, r);
        if (c == CHAR_NEWLINE) begin
            raw_next = 1'b1;
            return 1'b0;
        end
        if (c == sep.comment) begin
            in_cmt = 1'b1;
            return 1'b0;
        end
        return parse_record_byte(1'b0, c, r);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // Prediction, configuration tracking and result checking all happen at the rising edge.
    always @(posedge aclk) begin
        mapping_t want;
        in_fire <= s_tvalid && s_tready;
        if (!aresetn) begin
            sep        = DEFAULT_SEPARATORS;
            phase      = PH_START;
            acc        = '0;
            lo_store   = '0;
            hi_store   = '0;
            digit_seen = 1'b0;
            raw_next   = 1'b0;
            in_cmt     = 1'b0;
            draining   = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DELIM:   sep.delim   = cfg_data;
                    CFG_OPEN:    sep.open    = cfg_data;
                    CFG_DASH:    sep.dash    = cfg_data;
                    CFG_CLOSE:   sep.close   = cfg_data;
                    CFG_ARROW1:  sep.arrow1  = cfg_data;
                    CFG_ARROW2:  sep.arrow2  = cfg_data;
                    CFG_COMMENT: sep.comment = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (map_record_step(s_tlast, s_tdata, want)) expected_maps.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (expected_maps.size() == 0) begin
                    $error("unexpected result transaction: tdata %h, tuser %h", m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = expected_maps.pop_front();
                    check_field("source_low", want.source_low, m_tdata[31:0]);
                    check_field("source_high", want.source_high, m_tdata[63:32]);
                    check_field("target_low", want.target_low, m_tdata[95:64]);
                    check_field("target_high", want.target_high, m_tdata[127:96]);
                    check_field("status", 32'(want.status), 32'(m_tuser));
                end
            end
        end
    end

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Sender: a new byte is offered only after the previous transaction completed.
    always @(negedge aclk) begin
        text_byte_t nxt;
        if (aresetn && !(s_tvalid && !in_fire)) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (text_queue.size() != 0) begin
                nxt = text_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tlast  <= nxt.eof;
                send_gap <= no_send_gaps ? 0 : idle_length();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off while the sender keeps going.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (long_hold_req && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            hold_left       <= 200;
            m_tready        <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!no_recv_stalls && $urandom_range(3) == 0) recv_gap <= idle_length();
        end
    end

    task automatic push_byte(logic [7:0] b);
        record_text.push_back(b);
    endtask

    task automatic commit_text();
        foreach (record_text[i]) text_queue.push_back({1'b0, record_text[i]});
        bytes_queued += record_text.size();
        record_text.delete();
    endtask

    task automatic push_end();
        logic [7:0] junk;
        junk = 8'($urandom_range(255));
        text_queue.push_back({1'b1, junk});
        bytes_queued++;
    endtask

    task automatic push_string(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
        commit_text();
    endtask

    task automatic push_comment_body();
        logic [7:0] b;
        push_byte(sep.comment);
        repeat ($urandom_range(6)) begin
            b = 8'($urandom_range(255));
            if (b == CHAR_NEWLINE) b = 8'h20;
            push_byte(b);
        end
    endtask

    task automatic add_number();
        int unsigned n, style, v;
        push_byte(CHAR_BACKSLASH);
        push_byte($urandom_range(1) ? CHAR_LOWER_X : CHAR_UPPER_X);
        // Mostly up to eight digits; longer ones check that only the low bits are kept.
        n = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(12, 9);
        style = $urandom_range(9);
        repeat (n) begin
            v = (style == 0) ? 0 : (style == 1) ? 15 : $urandom_range(15);
            if (v < 10) push_byte(8'("0" + v));
            else if ($urandom_range(1)) push_byte(8'("a" + v - 10));
            else push_byte(8'("A" + v - 10));
        end
    endtask

    task automatic add_record();
        if ($urandom_range(3) == 0) push_byte(CHAR_NEWLINE);
        if ($urandom_range(9) == 0) begin
            push_comment_body();
            push_byte(CHAR_NEWLINE);
        end
        if ($urandom_range(1)) push_byte(sep.delim);
        if ($urandom_range(4) < 2) begin
            push_byte(sep.open);
            add_number();
            push_byte(sep.dash);
            add_number();
            push_byte(sep.close);
        end else begin
            add_number();
        end
        push_byte(sep.arrow1);
        push_byte(sep.arrow2);
        add_number();
    endtask

    task automatic damage_record();
        int unsigned k;
        if (record_text.size() == 0) return;
        k = $urandom_range(record_text.size() - 1);
        case ($urandom_range(3))
            0: record_text.delete(k);
            1: record_text[k] = 8'($urandom_range(255));
            2: while (record_text.size() > k) void'(record_text.pop_back());
            default: record_text.insert(k, 8'($urandom_range(255)));
        endcase
    endtask

    task automatic add_table_file();
        repeat ($urandom_range(6)) begin
            add_record();
            if ($urandom_range(11) == 0) damage_record();
            if ($urandom_range(19) == 0) begin
                repeat ($urandom_range(5, 1)) push_byte(8'($urandom_range(255)));
            end
            commit_text();
        end
        case ($urandom_range(7))
            0, 1: push_byte(CHAR_NEWLINE);
            2: push_comment_body();
            default: ;
        endcase
        commit_text();
        push_end();
    endtask

    function automatic logic [7:0] pick_mark();
        string marks;
        marks = ",;:[](){}<>-=~!@$%^&*|/?";
        return marks[$urandom_range(marks.len() - 1)];
    endfunction

    task automatic wait_until_idle();
        do @(posedge aclk);
        while (text_queue.size() != 0 || s_tvalid || expected_maps.size() != 0);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_separator(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
    endtask

    task automatic write_separators(cfg_t v);
        write_separator(CFG_DELIM, v.delim);
        write_separator(CFG_OPEN, v.open);
        write_separator(CFG_DASH, v.dash);
        write_separator(CFG_CLOSE, v.close);
        write_separator(CFG_ARROW1, v.arrow1);
        write_separator(CFG_ARROW2, v.arrow2);
        write_separator(CFG_COMMENT, v.comment);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        cfg_t        plan;
        int unsigned target;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed text under the reset separators.
        push_end();                    // end of input at record start
        push_string(",\\xF->\\X0");    // delimiter, upper-case X, end closes the target
        push_end();
        push_string("x");              // missing backslash
        push_end();
        push_string("\\x-");           // number without digits
        push_end();
        push_string(",");              // delimiter directly followed by end of input
        push_end();
        push_string("\\x1->\\x2q");    // bad byte right after a complete record
        push_end();

        for (int p = 0; p < 6; p++) begin
            wait_until_idle();
            plan = DEFAULT_SEPARATORS;
            case (p)
                1: plan = '0;
                2: begin
                    plan.delim   = pick_mark();
                    plan.open    = pick_mark();
                    plan.dash    = pick_mark();
                    plan.close   = pick_mark();
                    plan.arrow1  = pick_mark();
                    plan.arrow2  = pick_mark();
                    plan.comment = pick_mark();
                end
                3: plan = '1;
                4: plan = cfg_t'(56'({$urandom(), $urandom()}));
                default: ;
            endcase
            if (p != 0) write_separators(plan);
            no_send_gaps   = (p == 2 || p == 4);
            no_recv_stalls = (p == 4);
            long_hold_req  = (p == 2);
            target = bytes_queued + 330;
            while (bytes_queued < target) add_table_file();
        end
        wait_until_idle();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
design/crmp_pkg.sv
design/crmp_front.sv
design/crmp_fifo.sv
design/crmp_back.sv
design/code_range_mapping_parser_top.sv
tb/sv/tb_code_range_mapping_parser_top.sv
